### hdl/aljm_pkg.sv
`default_nettype none
package aljm_pkg;

   localparam int unsigned MinInertiaSumDefault = 1;

   localparam logic [1:0] OP_PREPARE   = 2'd0;
   localparam logic [1:0] OP_SOLVE_VEL = 2'd1;
   localparam logic [1:0] OP_SOLVE_POS = 2'd2;

   localparam logic [1:0] LIM_WITHIN = 2'd0;
   localparam logic [1:0] LIM_BELOW  = 2'd1;
   localparam logic [1:0] LIM_ABOVE  = 2'd2;

   localparam logic [2:0] CSR_ENABLE  = 3'd0;
   localparam logic [2:0] CSR_REF     = 3'd1;
   localparam logic [2:0] CSR_MIN     = 3'd2;
   localparam logic [2:0] CSR_MAX     = 3'd3;
   localparam logic [2:0] CSR_SPEED   = 3'd4;
   localparam logic [2:0] CSR_TORQUE  = 3'd5;
   localparam logic [2:0] CSR_DT      = 3'd6;
   localparam logic [2:0] CSR_CORR    = 3'd7;

   typedef struct packed {
      logic [1:0]         opcode;
      logic               present_a;
      logic               dynamic_a;
      logic signed [31:0] angle_a;
      logic signed [31:0] ang_vel_a;
      logic [30:0]        inv_inertia_a;
      logic               present_b;
      logic               dynamic_b;
      logic signed [31:0] angle_b;
      logic signed [31:0] ang_vel_b;
      logic [30:0]        inv_inertia_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_angle_a;
      logic signed [31:0] new_ang_vel_a;
      logic signed [31:0] new_angle_b;
      logic signed [31:0] new_ang_vel_b;
      logic [1:0]         limit_status;
      logic signed [31:0] impulse_total;
   } rsp_type;

   // divider control/status
   typedef struct packed {
      logic        start;
      logic        neg;
      logic [63:0] num;
      logic [31:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quo;
   } div_sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -66'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

endpackage
`default_nettype wire

### hdl/angular_limit_motor_joint_unit.sv
`default_nettype none
// Channel | direction | handshake      | payload
// req_    | in        | valid / stall  | opcode, body A and B state
// rsp_    | out       | valid / stall  | new angles, velocities, limit, impulse
// csr_    | in        | valid / ready  | register index, write data
//
// One transaction at a time. Prepare runs the 64-step reciprocal divider
// when the inertia sum exceeds MIN_INERTIA_SUM and otherwise goes straight
// to the limit check. Solve velocity runs up to seven multiplies on the
// shared 32x32 multiplier, each through S_MUL, S_MWT and S_MWB, then the
// output state. Solve position runs up to three multiplies plus one
// 64-step division. Reset clears the sequencer, configuration and joint
// state, not the working item or datapath registers. A stalled result holds
// in the output register and the next request waits until it is taken.
module angular_limit_motor_joint_unit #(
   parameter int unsigned MIN_INERTIA_SUM = aljm_pkg::MinInertiaSumDefault
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  aljm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output aljm_pkg::rsp_type rsp_data,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire  [2:0]        csr_index,
   input  wire  [31:0]       csr_wdata
);
   import aljm_pkg::*;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PDIV  = 4'd1;  // prepare: reciprocal
   localparam logic [3:0] S_PLIM  = 4'd2;  // prepare: limits
   localparam logic [3:0] S_MUL   = 4'd3;  // issue multiply
   localparam logic [3:0] S_MWB   = 4'd4;  // consume product
   localparam logic [3:0] S_WDIV  = 4'd5;  // position division wait
   localparam logic [3:0] S_OUT   = 4'd6;
   localparam logic [3:0] S_MWT   = 4'd7;  // multiply in progress

   // micro-steps for the multiply sequence
   localparam logic [3:0] M_MOT_LAM = 4'd0;  // lam = m * e
   localparam logic [3:0] M_MOT_LIM = 4'd1;  // lim = torque * dt
   localparam logic [3:0] M_MOT_A   = 4'd2;
   localparam logic [3:0] M_MOT_B   = 4'd3;
   localparam logic [3:0] M_LIM_LAM = 4'd4;
   localparam logic [3:0] M_LIM_A   = 4'd5;
   localparam logic [3:0] M_LIM_B   = 4'd6;
   localparam logic [3:0] M_POS_FE  = 4'd7;
   localparam logic [3:0] M_POS_A   = 4'd8;
   localparam logic [3:0] M_POS_B   = 4'd9;

   localparam logic [31:0] MinSum = 32'(MIN_INERTIA_SUM);

   // configuration
   logic               en_ff;
   logic signed [31:0] ref_ff, min_ff, max_ff, speed_ff;
   logic [30:0]        torque_ff, dt_ff;
   logic [16:0]        corr_ff;

   // joint state
   logic signed [31:0] mass_ff, mass_in, err_ff, err_in, isum_ff, isum_in;
   logic [1:0]         lst_ff, lst_in;

   // working item
   logic [3:0]         st_ff, st_in, step_ff, step_in;
   logic               da_ff, da_in, db_ff, db_in;
   logic signed [31:0] aa_ff, aa_in, va_ff, va_in, ab_ff, ab_in, vb_ff, vb_in;
   logic [30:0]        ia_ff, ia_in, ib_ff, ib_in;
   logic signed [31:0] lam_ff, lam_in, pcorr_ff, pcorr_in;
   logic               rv_ff, rv_in;
   rsp_type            rsp_ff, rsp_in;

   // shared multiplier: operands registered, product registered
   logic signed [31:0] ma_ff, ma_in, mb_ff, mb_in;
   logic signed [63:0] prod_ff;
   logic signed [31:0] qprod;

   div_cmd_type dcmd;
   div_sts_type dsts;

   logic [31:0]        ksum;
   logic signed [33:0] rel;
   logic signed [32:0] relw;

   aljm_div u_div (.clock(clock), .reset(reset), .cmd(dcmd), .sts(dsts));

   assign ksum  = {1'b0, ia_ff} + {1'b0, ib_ff};
   assign qprod = sat32(66'(prod_ff >>> 16));
   assign rel   = 34'(ab_ff) - 34'(aa_ff) - 34'(ref_ff);
   assign relw  = 33'(vb_ff) - 33'(va_ff);

   assign req_stall = (st_ff != S_IDLE) || rv_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      st_in = st_ff;  step_in = step_ff;
      da_in = da_ff;  db_in = db_ff;
      aa_in = aa_ff;  va_in = va_ff;  ab_in = ab_ff;  vb_in = vb_ff;
      ia_in = ia_ff;  ib_in = ib_ff;
      lam_in = lam_ff;  pcorr_in = pcorr_ff;
      mass_in = mass_ff;  err_in = err_ff;  isum_in = isum_ff;  lst_in = lst_ff;
      ma_in = ma_ff;  mb_in = mb_ff;
      rv_in = rv_ff;  rsp_in = rsp_ff;
      dcmd = '0;

      if (rv_ff && !rsp_stall) rv_in = 1'b0;

      unique case (st_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               // absent bodies read as zero; only dynamic bodies have inertia
               da_in = req_data.present_a & req_data.dynamic_a;
               db_in = req_data.present_b & req_data.dynamic_b;
               aa_in = req_data.present_a ? req_data.angle_a : '0;
               va_in = req_data.present_a ? req_data.ang_vel_a : '0;
               ab_in = req_data.present_b ? req_data.angle_b : '0;
               vb_in = req_data.present_b ? req_data.ang_vel_b : '0;
               ia_in = (req_data.present_a & req_data.dynamic_a)
                       ? req_data.inv_inertia_a : '0;
               ib_in = (req_data.present_b & req_data.dynamic_b)
                       ? req_data.inv_inertia_b : '0;
               priority case (req_data.opcode)
                  OP_PREPARE: st_in = S_PDIV;
                  OP_SOLVE_VEL: begin
                     if (!en_ff) st_in = S_OUT;
                     else if (torque_ff != '0) begin
                        step_in = M_MOT_LAM;  st_in = S_MUL;
                     end else if (lst_ff != LIM_WITHIN) begin
                        step_in = M_LIM_LAM;  st_in = S_MUL;
                     end else st_in = S_OUT;
                  end
                  OP_SOLVE_POS: begin
                     if (en_ff && lst_ff != LIM_WITHIN) begin
                        step_in = M_POS_FE;  st_in = S_MUL;
                     end else st_in = S_OUT;
                  end
                  default: st_in = S_OUT;
               endcase
            end
         end

         S_PDIV: begin
            // kick the reciprocal once; wait for it when it is needed
            if (ksum > MinSum) begin
               if (!dsts.busy && !dsts.done) begin
                  dcmd.start = 1'b1;
                  dcmd.num   = 64'h1_0000_0000;
                  dcmd.den   = ksum;
               end
               if (dsts.done) begin
                  mass_in = sat32(66'($signed({1'b0, dsts.quo})));
                  st_in   = S_PLIM;
               end
            end else begin
               mass_in = '0;
               st_in   = S_PLIM;
            end
         end

         S_PLIM: begin
            if (rel < 34'(min_ff)) begin
               lst_in = LIM_BELOW;  err_in = sat32(66'(rel - 34'(min_ff)));
            end else if (rel > 34'(max_ff)) begin
               lst_in = LIM_ABOVE;  err_in = sat32(66'(rel - 34'(max_ff)));
            end else begin
               lst_in = LIM_WITHIN;  err_in = '0;
            end
            st_in = S_OUT;
         end

         S_MUL: begin
            unique case (step_ff)
               M_MOT_LAM: begin
                  ma_in = mass_ff;
                  mb_in = sat32(66'(speed_ff) - 66'(sat32(66'(relw))));
               end
               M_MOT_LIM: begin ma_in = {1'b0, torque_ff};  mb_in = {1'b0, dt_ff}; end
               M_MOT_A, M_LIM_A, M_POS_A: begin
                  ma_in = {1'b0, ia_ff};
                  mb_in = (step_ff == M_POS_A) ? pcorr_ff : lam_ff;
               end
               M_MOT_B, M_LIM_B, M_POS_B: begin
                  ma_in = {1'b0, ib_ff};
                  mb_in = (step_ff == M_POS_B) ? pcorr_ff : lam_ff;
               end
               M_LIM_LAM: begin ma_in = mass_ff;  mb_in = sat32(66'(relw)); end
               M_POS_FE:  begin ma_in = {15'd0, corr_ff};  mb_in = err_ff; end
               default: ;
            endcase
            st_in = S_MWT;
         end

         // hold while the product register loads from the latched operands
         S_MWT: st_in = S_MWB;

         S_MWB: begin
            st_in = S_MUL;
            unique case (step_ff)
               M_MOT_LAM: begin lam_in = qprod;  step_in = M_MOT_LIM; end
               M_MOT_LIM: begin
                  // clamp motor impulse to +/- torque*dt
                  if (lam_ff > qprod) lam_in = qprod;
                  else if (lam_ff < -qprod) lam_in = -qprod;
                  step_in = M_MOT_A;
               end
               M_MOT_A: begin
                  if (da_ff) va_in = sat32(66'(va_ff) - 66'(qprod));
                  step_in = M_MOT_B;
               end
               M_MOT_B: begin
                  if (db_ff) vb_in = sat32(66'(vb_ff) + 66'(qprod));
                  if (lst_ff != LIM_WITHIN) step_in = M_LIM_LAM;
                  else st_in = S_OUT;
               end
               M_LIM_LAM: begin
                  lam_in = sat32(-66'(qprod));
                  if (lst_ff == LIM_BELOW && sat32(-66'(qprod)) < 0) lam_in = '0;
                  if (lst_ff == LIM_ABOVE && sat32(-66'(qprod)) > 0) lam_in = '0;
                  step_in = M_LIM_A;
               end
               M_LIM_A: begin
                  isum_in = sat32(66'(isum_ff) + 66'(lam_ff));
                  if (da_ff) va_in = sat32(66'(va_ff) - 66'(qprod));
                  step_in = M_LIM_B;
               end
               M_LIM_B: begin
                  if (db_ff) vb_in = sat32(66'(vb_ff) + 66'(qprod));
                  st_in = S_OUT;
               end
               M_POS_FE: begin
                  if (ksum != '0 && ksum >= MinSum) begin
                     dcmd.start = 1'b1;
                     dcmd.neg   = qprod[31];
                     dcmd.num   = {16'd0, (qprod[31] ? -33'(qprod) : 33'(qprod)), 15'd0}
                                  << 1;
                     dcmd.den   = ksum;
                     st_in      = S_WDIV;
                  end else st_in = S_OUT;
               end
               M_POS_A: begin
                  if (da_ff) aa_in = sat32(66'(aa_ff) + 66'(qprod));
                  step_in = M_POS_B;
               end
               M_POS_B: begin
                  if (db_ff) ab_in = sat32(66'(ab_ff) - 66'(qprod));
                  st_in = S_OUT;
               end
               default: st_in = S_OUT;
            endcase
         end

         S_WDIV: begin
            if (dsts.done) begin
               pcorr_in = sat32(66'($signed(dsts.quo)));
               step_in  = M_POS_A;
               st_in    = S_MUL;
            end
         end

         S_OUT: begin
            // results go out in the register; hold off while one still waits
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               rsp_in.new_angle_a   = aa_ff;
               rsp_in.new_ang_vel_a = va_ff;
               rsp_in.new_angle_b   = ab_ff;
               rsp_in.new_ang_vel_b = vb_ff;
               rsp_in.limit_status  = lst_ff;
               rsp_in.impulse_total = isum_ff;
               st_in = S_IDLE;
            end
         end

         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;  rv_ff <= 1'b0;
         en_ff <= 1'b0;  ref_ff <= '0;  min_ff <= '0;  max_ff <= '0;
         speed_ff <= '0;  torque_ff <= '0;  dt_ff <= '0;  corr_ff <= '0;
         mass_ff <= '0;  err_ff <= '0;  isum_ff <= '0;  lst_ff <= LIM_WITHIN;
      end else begin
         st_ff <= st_in;  rv_ff <= rv_in;
         mass_ff <= mass_in;  err_ff <= err_in;  isum_ff <= isum_in;
         lst_ff <= lst_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ENABLE: en_ff     <= csr_wdata[0];
               CSR_REF:    ref_ff    <= csr_wdata;
               CSR_MIN:    min_ff    <= csr_wdata;
               CSR_MAX:    max_ff    <= csr_wdata;
               CSR_SPEED:  speed_ff  <= csr_wdata;
               CSR_TORQUE: torque_ff <= csr_wdata[30:0];
               CSR_DT:     dt_ff     <= csr_wdata[30:0];
               CSR_CORR:   corr_ff   <= csr_wdata[16:0];
               default: ;
            endcase
         end
      end
      step_ff <= step_in;  da_ff <= da_in;  db_ff <= db_in;
      aa_ff <= aa_in;  va_ff <= va_in;  ab_ff <= ab_in;  vb_ff <= vb_in;
      ia_ff <= ia_in;  ib_ff <= ib_in;  lam_ff <= lam_in;  pcorr_ff <= pcorr_in;
      ma_ff <= ma_in;  mb_ff <= mb_in;  rsp_ff <= rsp_in;
      prod_ff <= ma_ff * mb_ff;
   end

   // Operands latch leaving S_MUL, the product latches leaving S_MWT, and
   // S_MWB reads the product of the operands chosen in S_MUL.

   ap_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> req_stall) else $error("request taken while busy");
   ap_lim_code: assert property (@(posedge clock) disable iff (reset)
      (lst_ff != 2'd3)) else $error("bad limit state");
   ap_div_only_busy: assert property (@(posedge clock) disable iff (reset)
      dsts.done |-> (st_ff == S_PDIV || st_ff == S_WDIV))
      else $error("divider result unclaimed");

endmodule
`default_nettype wire

### hdl/aljm_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, unsigned magnitude in,
// sign applied at the end (truncation toward zero).
module aljm_div (
   input  wire                   clock,
   input  wire                   reset,
   input  aljm_pkg::div_cmd_type cmd,
   output aljm_pkg::div_sts_type sts
);
   import aljm_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]};
      if (cmd.start) begin
         quo_in  = cmd.num;
         rem_in  = '0;
         den_in  = cmd.den;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
         neg_in  = cmd.neg;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.quo  = neg_ff ? (~quo_ff + 64'd1) : quo_ff;

endmodule
`default_nettype wire
